FILE: rtl/fac_pkg.sv
// shared types, constants and helpers of the feistel arx cbc cipher
`default_nettype none
package fac_pkg;

  localparam int DEF_NUM_ROUNDS = 12;
  localparam int WORD_W         = 64;
  localparam int SLOT_W         = 4;
  localparam int OPCODE_W       = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;

  localparam logic [WORD_W-1:0] ROUND_CONST = 64'hFFFF_FFFF_FFFF_FFFD;

  localparam int ROT_MIX  = 13;
  localparam int ROT_FOLD = 17;
  localparam int ROT_OUT  = 11;

  // item operation codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD = 2'd0,
    OP_ENC  = 2'd1,
    OP_DEC  = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAIN_ENABLE = 2'd2;

  // the three add steps of one round on the shared adder
  typedef enum logic [1:0] {
    PH_MIX  = 2'd0,
    PH_FOLD = 2'd1,
    PH_OUT  = 2'd2
  } phase_t;

  typedef struct packed {
    logic   load;
    logic   step;
    phase_t phase;
  } rnd_ctl_t;

  function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                               input int unsigned s);
    rotl64 = (v << s) | (v >> (WORD_W - s));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/fac_in_if.sv
// input item channel of the cipher
`default_nettype none
interface fac_in_if
  import fac_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SLOT_W-1:0]   key_slot;
  logic [WORD_W-1:0]   key_first_word;
  logic [WORD_W-1:0]   key_second_word;
  logic [WORD_W-1:0]   block_low;
  logic [WORD_W-1:0]   block_high;
  logic                chain_restart;

  modport source (
    output valid, opcode, key_slot, key_first_word, key_second_word,
           block_low, block_high, chain_restart,
    input  ready
  );
  modport sink (
    input  valid, opcode, key_slot, key_first_word, key_second_word,
           block_low, block_high, chain_restart,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/fac_out_if.sv
// result item channel of the cipher
`default_nettype none
interface fac_out_if
  import fac_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] result_low;
  logic [WORD_W-1:0] result_high;

  modport source (output valid, result_low, result_high, input ready);
  modport sink (input valid, result_low, result_high, output ready);
endinterface
`default_nettype wire

FILE: rtl/fac_key_store.sv
// round key memory, one write port and one registered read port
`default_nettype none
module fac_key_store
  import fac_pkg::*;
#(
  parameter int DEPTH = DEF_NUM_ROUNDS,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [WORD_W-1:0]   wr_k0,
  input  logic [WORD_W-1:0]   wr_k1,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output logic [WORD_W-1:0]   rd_k0,
  output logic [WORD_W-1:0]   rd_k1
);

  logic [2*WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_k1, wr_k0};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_k1, rd_k0} <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/fac_round_unit.sv
// feistel half registers and the shared 64-bit adder of the round function
`default_nettype none
module fac_round_unit
  import fac_pkg::*;
(
  input  logic              clk,
  input  rnd_ctl_t          ctl,
  input  logic [WORD_W-1:0] init_x,
  input  logic [WORD_W-1:0] init_y,
  input  logic [WORD_W-1:0] k0,
  input  logic [WORD_W-1:0] k1,
  output logic [WORD_W-1:0] x,
  output logic [WORD_W-1:0] y
);

  logic [WORD_W-1:0] t;
  logic [WORD_W-1:0] add_a;
  logic [WORD_W-1:0] add_b;
  logic [WORD_W-1:0] sum;

  // operand selection for the one adder
  always_comb begin
    case (ctl.phase)
      PH_MIX: begin
        add_a = y;
        add_b = k0;
      end
      PH_FOLD: begin
        add_a = rotl64(t, ROT_FOLD);
        add_b = ROUND_CONST;
      end
      PH_OUT: begin
        add_a = rotl64(t, ROT_OUT);
        add_b = k0;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign sum = add_a + add_b;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= init_x;
      y <= init_y;
    end else if (ctl.step) begin
      case (ctl.phase)
        PH_MIX:  t <= rotl64(sum, ROT_MIX) ^ k1;
        PH_FOLD: t <= sum ^ y;
        PH_OUT: begin
          x <= y;
          y <= x ^ sum;
        end
        default: t <= t;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/feistel_arx_cbc_cipher_unit.sv
// top level: sequencer, chaining state, configuration and result register
// A 128-bit Feistel cipher with NUM_ROUNDS rounds and optional CBC chaining.
// An encrypt or decrypt item is taken in idle, runs its rounds, then passes a
// finish state that places its result in the output register as the block
// returns to idle, where it can take the next item. Each round runs its three
// additions one after another on a single 64-bit adder, and the sequencer
// accepts no item from start to finish. Load and unused-opcode items leave the
// block idle and give no result. The result sits in an output register, so the
// next item is taken while a result still waits; a finished block waits there
// only if the previous result has not yet been taken. Round keys are loaded by
// load items; a key slot at or above NUM_ROUNDS is ignored, and reading a
// never-loaded key gives an undefined result. Configuration is to be written by
// cfg_write with cfg_index 0 (iv low), 1 (iv high) or 2 (chain enable), only
// while idle; the block itself does not enforce this.
`default_nettype none
module feistel_arx_cbc_cipher_unit
  import fac_pkg::*;
#(
  parameter int NUM_ROUNDS = DEF_NUM_ROUNDS
) (
  input  logic                  clk,
  input  logic                  rst,
  fac_in_if.sink                req,
  fac_out_if.source             rsp,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RW = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
  // slot compare width, wide enough to hold NUM_ROUNDS itself
  localparam int SW = (RW + 1 > SLOT_W) ? RW + 1 : SLOT_W;
  localparam logic [RW-1:0] LAST = RW'(NUM_ROUNDS - 1);

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_RUN    = 2'd1,
    S_FINISH = 2'd2
  } state_t;

  state_t  state;
  phase_t  phase;
  logic [RW-1:0] cnt;
  logic [RW-1:0] cnt_next;

  // configuration registers
  logic [WORD_W-1:0] iv_low;
  logic [WORD_W-1:0] iv_high;
  logic              chain_en;

  // chaining value and per-item working copies
  logic [WORD_W-1:0] chain_lo;
  logic [WORD_W-1:0] chain_hi;
  logic              is_dec;
  logic [WORD_W-1:0] pv_lo;
  logic [WORD_W-1:0] pv_hi;
  logic [WORD_W-1:0] cin_lo;
  logic [WORD_W-1:0] cin_hi;

  // result register
  logic              out_valid;
  logic [WORD_W-1:0] res_lo;
  logic [WORD_W-1:0] res_hi;

  logic              accept;
  logic              start;
  logic              start_dec;
  logic              kw_en;
  logic [SW-1:0]     slot_ext;
  logic [WORD_W-1:0] prev_lo;
  logic [WORD_W-1:0] prev_hi;
  logic [WORD_W-1:0] init_x;
  logic [WORD_W-1:0] init_y;
  logic              rd_en;
  logic [RW-1:0]     rd_addr;
  logic [WORD_W-1:0] k0;
  logic [WORD_W-1:0] k1;
  logic [WORD_W-1:0] x;
  logic [WORD_W-1:0] y;
  logic [WORD_W-1:0] fin_lo;
  logic [WORD_W-1:0] fin_hi;
  logic              drain_ok;
  rnd_ctl_t          ctl;

  // ---- configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      iv_low   <= '0;
      iv_high  <= '0;
      chain_en <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IV_LOW:       iv_low   <= cfg_data;
        REG_IV_HIGH:      iv_high  <= cfg_data;
        REG_CHAIN_ENABLE: chain_en <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // ---- input side
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign start_dec = (req.opcode == OP_DEC);
  assign start     = accept && ((req.opcode == OP_ENC) || start_dec);
  assign slot_ext  = SW'(req.key_slot);
  assign kw_en     = accept && (req.opcode == OP_LOAD) && (slot_ext < SW'(NUM_ROUNDS));

  // restart picks the iv only when chaining is on
  assign prev_lo = (chain_en && req.chain_restart) ? iv_low  : chain_lo;
  assign prev_hi = (chain_en && req.chain_restart) ? iv_high : chain_hi;

  // decryption runs the same round on swapped halves
  always_comb begin
    if (start_dec) begin
      init_x = req.block_high;
      init_y = req.block_low;
    end else if (chain_en) begin
      init_x = req.block_low  ^ prev_lo;
      init_y = req.block_high ^ prev_hi;
    end else begin
      init_x = req.block_low;
      init_y = req.block_high;
    end
  end

  // ---- key fetch: first round at acceptance, next round in each final phase
  // but the last
  assign cnt_next = cnt + 1'b1;
  assign rd_en    = start || ((state == S_RUN) && (phase == PH_OUT) && (cnt != LAST));

  always_comb begin
    if (start) begin
      rd_addr = start_dec ? LAST : '0;
    end else begin
      rd_addr = is_dec ? (LAST - cnt_next) : cnt_next;
    end
  end

  fac_key_store #(
    .DEPTH (NUM_ROUNDS),
    .AW    (RW)
  ) u_keys (
    .clk     (clk),
    .wr_en   (kw_en),
    .wr_addr (slot_ext[RW-1:0]),
    .wr_k0   (req.key_first_word),
    .wr_k1   (req.key_second_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_k0   (k0),
    .rd_k1   (k1)
  );

  // ---- round datapath
  assign ctl.load  = start;
  assign ctl.step  = (state == S_RUN);
  assign ctl.phase = phase;

  fac_round_unit u_round (
    .clk    (clk),
    .ctl    (ctl),
    .init_x (init_x),
    .init_y (init_y),
    .k0     (k0),
    .k1     (k1),
    .x      (x),
    .y      (y)
  );

  // ---- finish: for decryption, unswap and apply the chaining value
  always_comb begin
    if (is_dec) begin
      fin_lo = chain_en ? (y ^ pv_lo) : y;
      fin_hi = chain_en ? (x ^ pv_hi) : x;
    end else begin
      fin_lo = x;
      fin_hi = y;
    end
  end

  assign drain_ok = !out_valid || rsp.ready;

  // ---- sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_MIX;
      cnt       <= '0;
      out_valid <= 1'b0;
      chain_lo  <= '0;
      chain_hi  <= '0;
    end else begin
      // a finished block fills the result register once it is empty or the old one leaves
      if ((state == S_FINISH) && drain_ok) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
            phase <= PH_MIX;
            cnt   <= '0;
          end
        end
        S_RUN: begin
          case (phase)
            PH_MIX:  phase <= PH_FOLD;
            PH_FOLD: phase <= PH_OUT;
            PH_OUT: begin
              phase <= PH_MIX;
              cnt   <= cnt_next;
              if (cnt == LAST) begin
                state <= S_FINISH;
              end
            end
            default: phase <= PH_MIX;
          endcase
        end
        S_FINISH: begin
          if (drain_ok) begin
            state <= S_IDLE;
            // encryption chains on its output, decryption on its input
            if (chain_en) begin
              chain_lo <= is_dec ? cin_lo : fin_lo;
              chain_hi <= is_dec ? cin_hi : fin_hi;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- payload registers
  always_ff @(posedge clk) begin
    if (start) begin
      is_dec <= start_dec;
      pv_lo  <= prev_lo;
      pv_hi  <= prev_hi;
      cin_lo <= req.block_low;
      cin_hi <= req.block_high;
    end
    if ((state == S_FINISH) && drain_ok) begin
      res_lo <= fin_lo;
      res_hi <= fin_hi;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_low  = res_lo;
  assign rsp.result_high = res_hi;

  // ---- checks
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == S_RUN) && (cnt == '0) && (phase == PH_MIX))
    else $error("cipher item did not start at the first round");

  a_last_round_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) && (phase == PH_OUT) && (cnt == LAST) |=> (state == S_FINISH))
    else $error("sequencer ran past the last round");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_FINISH))
    else $error("result offered without a finished block");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) && drain_ok |=> rsp.valid && (state == S_IDLE))
    else $error("finished block not placed in result register");

  a_no_load_when_busy: assert property (@(posedge clk) disable iff (rst)
    kw_en |-> (state == S_IDLE))
    else $error("key store written while a block is in flight");

endmodule
`default_nettype wire

FILE: tb/tb_feistel_arx_cbc_cipher_unit.sv
// self-checking testbench of the feistel arx cbc cipher unit
`timescale 1ns / 1ps
module tb_feistel_arx_cbc_cipher_unit;
  import fac_pkg::*;

  // block configuration and the timing figures taken from it
  localparam int ROUNDS        = DEF_NUM_ROUNDS;
  localparam int BLOCK_LATENCY = 3 * ROUNDS + 1;   // acceptance to result offered
  localparam int SETTLE_CYCLES = BLOCK_LATENCY + 8;
  localparam int HOLD_CYCLES   = 300;              // long receiver hold-off
  localparam int HOLD_AFTER    = 60;               // results taken before the hold-off
  localparam int WATCH_LIMIT   = 2000;             // cycles with no item moving

  // one input item as the sender drives it
  typedef struct {
    opcode_t           op;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    logic              restart;
  } cipher_item_t;

  // one 128-bit block as it appears on the result channel
  typedef struct {
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
  } cipher_block_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fac_in_if  req_ch ();
  fac_out_if rsp_ch ();

  feistel_arx_cbc_cipher_unit #(
    .NUM_ROUNDS (ROUNDS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch.sink),
    .rsp       (rsp_ch.source),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // items waiting to be offered, and the blocks the cipher should return
  cipher_item_t  pending_items[$];
  cipher_block_t expected_blocks[$];
  cipher_item_t  item_on_bus;

  int items_queued   = 0;
  int items_accepted = 0;
  int results_taken  = 0;
  int error_count    = 0;
  int send_gap_pct   = 0;   // chance per cycle that the sender holds back
  int recv_stall_pct = 0;   // chance per cycle that the receiver drops ready
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  int quiet_cycles   = 0;

  // predictor state: round keys, chaining value and register copies
  logic [WORD_W-1:0] round_k0[ROUNDS];
  logic [WORD_W-1:0] round_k1[ROUNDS];
  logic [WORD_W-1:0] chain_lo, chain_hi;
  logic [WORD_W-1:0] iv_lo, iv_hi;
  logic              chaining_on;

  // arx round function: add, rotate, xor, rotate, add constant, fold, rotate, add
  function automatic logic [WORD_W-1:0] arx_mix(input logic [WORD_W-1:0] r,
                                                input logic [WORD_W-1:0] k0,
                                                input logic [WORD_W-1:0] k1);
    logic [WORD_W-1:0] x;
    x = r + k0;
    x = {x[50:0], x[63:51]} ^ k1;
    x = {x[46:0], x[63:47]} + ROUND_CONST;
    x = x ^ r;
    return {x[52:0], x[63:53]} + k0;
  endfunction

  // work out what an accepted item does to the key store and chaining value,
  // and queue the block it should return
  function automatic void predict_cipher(input cipher_item_t it);
    logic [WORD_W-1:0] l, r, t, plo, phi;
    cipher_block_t     blk;
    case (it.op)
      OP_LOAD: begin
        // a slot beyond the last round is dropped
        if (it.slot < ROUNDS) begin
          round_k0[it.slot] = it.k0;
          round_k1[it.slot] = it.k1;
        end
      end
      OP_ENC, OP_DEC: begin
        if (chaining_on && it.restart) begin
          plo = iv_lo;
          phi = iv_hi;
        end else begin
          plo = chain_lo;
          phi = chain_hi;
        end
        l = it.lo;
        r = it.hi;
        if (it.op == OP_ENC) begin
          if (chaining_on) begin
            l = l ^ plo;
            r = r ^ phi;
          end
          for (int i = 0; i < ROUNDS; i++) begin
            t = l ^ arx_mix(r, round_k0[i], round_k1[i]);
            l = r;
            r = t;
          end
          // ciphertext out becomes the next chaining value
          if (chaining_on) begin
            chain_lo = l;
            chain_hi = r;
          end
        end else begin
          for (int i = ROUNDS - 1; i >= 0; i--) begin
            t = r ^ arx_mix(l, round_k0[i], round_k1[i]);
            r = l;
            l = t;
          end
          // ciphertext in becomes the next chaining value
          if (chaining_on) begin
            l = l ^ plo;
            r = r ^ phi;
            chain_lo = it.lo;
            chain_hi = it.hi;
          end
        end
        blk.lo = l;
        blk.hi = r;
        expected_blocks.push_back(blk);
      end
      default: begin
        // unused opcode: nothing happens
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("mismatch @%0t: %s got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // sender: offers queued items, holds each one until it is taken
  always @(posedge clk) begin : drive_items
    bit send;
    if (rst) begin
      req_ch.valid           <= 1'b0;
      req_ch.opcode          <= OP_NONE;
      req_ch.key_slot        <= '0;
      req_ch.key_first_word  <= '0;
      req_ch.key_second_word <= '0;
      req_ch.block_low       <= '0;
      req_ch.block_high      <= '0;
      req_ch.chain_restart   <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_cipher(item_on_bus);
        items_accepted++;
      end
      // free to change the bus only when nothing is waiting on it
      if (!req_ch.valid || req_ch.ready) begin
        send = (pending_items.size() != 0) && ($urandom_range(0, 99) >= send_gap_pct);
        if (send) begin
          item_on_bus = pending_items.pop_front();
          req_ch.opcode          <= item_on_bus.op;
          req_ch.key_slot        <= item_on_bus.slot;
          req_ch.key_first_word  <= item_on_bus.k0;
          req_ch.key_second_word <= item_on_bus.k1;
          req_ch.block_low       <= item_on_bus.lo;
          req_ch.block_high      <= item_on_bus.hi;
          req_ch.chain_restart   <= item_on_bus.restart;
        end
        req_ch.valid <= send;
      end
    end
  end

  // receiver: checks each taken result against the oldest prediction,
  // then decides ready for the next cycle (random stalls, one long hold-off)
  always @(posedge clk) begin : take_results
    cipher_block_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_taken++;
        if (expected_blocks.size() == 0) begin
          report_mismatch("unexpected result, low half", rsp_ch.result_low, '0);
        end else begin
          want = expected_blocks.pop_front();
          if (rsp_ch.result_low !== want.lo)
            report_mismatch("result_low", rsp_ch.result_low, want.lo);
          if (rsp_ch.result_high !== want.hi)
            report_mismatch("result_high", rsp_ch.result_high, want.hi);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && results_taken >= HOLD_AFTER) begin
        // sender keeps offering, so the result register fills and input stalls
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles in which no item moves on either channel
  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("tb_feistel_arx_cbc_cipher_unit: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic cipher_item_t make_item(input opcode_t op,
                                             input logic [SLOT_W-1:0] slot,
                                             input logic [WORD_W-1:0] k0,
                                             input logic [WORD_W-1:0] k1,
                                             input logic [WORD_W-1:0] lo,
                                             input logic [WORD_W-1:0] hi,
                                             input logic restart);
    cipher_item_t it;
    it.op      = op;
    it.slot    = slot;
    it.k0      = k0;
    it.k1      = k1;
    it.lo      = lo;
    it.hi      = hi;
    it.restart = restart;
    return it;
  endfunction

  task automatic queue_item(input cipher_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  // register write; the predictor copy changes with it, the block being idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_IV_LOW:       iv_lo = value;
      REG_IV_HIGH:      iv_hi = value;
      REG_CHAIN_ENABLE: chaining_on = value[0];
      default:          ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // random traffic, mostly blocks with some key reloads and unused opcodes;
  // ignored items are not counted
  task automatic queue_random(input int count);
    int           done;
    int           pick;
    cipher_item_t it;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      it = make_item(OP_ENC, SLOT_W'($urandom_range(0, 15)), pick_word(), pick_word(),
                     pick_word(), pick_word(), ($urandom_range(0, 3) == 0));
      if (pick < 8)
        it.op = OP_LOAD;
      else if (pick < 11)
        it.op = OP_NONE;
      else if (pick >= 56)
        it.op = OP_DEC;
      queue_item(it);
      if (it.op != OP_NONE && !(it.op == OP_LOAD && it.slot >= ROUNDS))
        done++;
    end
  endtask

  // wait for every item taken and every result back, then let the block go quiet
  task automatic settle();
    do
      @(negedge clk);
    while (items_accepted != items_queued || expected_blocks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    // reset and configuration port known before the first edge
    rst                    = 1'b1;
    cfg_write              = 1'b0;
    cfg_index              = REG_IV_LOW;
    cfg_data               = '0;

    // reset state of the predictor
    iv_lo       = '0;
    iv_hi       = '0;
    chaining_on = 1'b1;
    chain_lo    = '0;
    chain_hi    = '0;
    for (int i = 0; i < ROUNDS; i++) begin
      round_k0[i] = '0;
      round_k1[i] = '0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // first setting: all-ones iv, chaining on; sender idles lightly,
    // receiver heavily
    write_reg(REG_IV_LOW, '1);
    write_reg(REG_IV_HIGH, '1);
    write_reg(REG_CHAIN_ENABLE, 64'd1);
    send_gap_pct   = 16;
    recv_stall_pct = 46;
    @(negedge clk);

    // every round key loaded before any block, zero and all-ones keys at the ends
    queue_item(make_item(OP_LOAD, 4'd0, '0, '0, '1, '1, 1'b1));
    for (int i = 1; i < ROUNDS - 1; i++)
      queue_item(make_item(OP_LOAD, SLOT_W'(i), pick_word(), pick_word(), pick_word(),
                           pick_word(), 1'($urandom_range(0, 1))));
    queue_item(make_item(OP_LOAD, SLOT_W'(ROUNDS - 1), '1, '1, '0, '0, 1'b0));
    // slots past the last round must not land anywhere
    queue_item(make_item(OP_LOAD, 4'd12, '1, '0, '0, '0, 1'b0));
    queue_item(make_item(OP_LOAD, 4'd15, '0, '1, '1, '1, 1'b1));
    // first block after reset without restart chains from zero
    queue_item(make_item(OP_ENC, 4'd0, '0, '0, '0, '0, 1'b0));
    queue_item(make_item(OP_ENC, 4'd15, '1, '1, '1, '1, 1'b1));
    queue_item(make_item(OP_DEC, 4'd3, '0, '0, pick_word(), pick_word(), 1'b0));
    queue_item(make_item(OP_DEC, 4'd7, '1, '1, '0, '0, 1'b1));
    // unused opcode in the middle of a chain
    queue_item(make_item(OP_NONE, 4'd15, '1, '1, '1, '1, 1'b1));
    queue_item(make_item(OP_ENC, 4'd0, '0, '0, '0, '1, 1'b0));
    queue_item(make_item(OP_DEC, 4'd0, '0, '0, '1, '0, 1'b1));
    // key reload between blocks
    queue_item(make_item(OP_LOAD, 4'd5, pick_word(), pick_word(), '0, '0, 1'b0));
    queue_item(make_item(OP_ENC, 4'd2, '0, '0, pick_word(), pick_word(), 1'b0));
    queue_random(150);
    settle();

    // chaining off with a random iv: restart ignored, chain value kept
    write_reg(REG_IV_LOW, {$urandom, $urandom});
    write_reg(REG_IV_HIGH, {$urandom, $urandom});
    write_reg(REG_CHAIN_ENABLE, 64'd0);
    @(negedge clk);
    queue_random(120);
    settle();

    // chaining back on from a zero iv; receiver idles lightly, sender heavily
    write_reg(REG_IV_LOW, '0);
    write_reg(REG_IV_HIGH, '0);
    write_reg(REG_CHAIN_ENABLE, 64'd1);
    send_gap_pct   = 46;
    recv_stall_pct = 16;
    @(negedge clk);
    queue_random(150);
    settle();

    // random iv, chaining on, no idling on either side
    write_reg(REG_IV_LOW, {$urandom, $urandom});
    write_reg(REG_IV_HIGH, {$urandom, $urandom});
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    queue_random(180);
    settle();

    while (expected_blocks.size() != 0) begin
      report_mismatch("result never returned, low half", '0, expected_blocks[0].lo);
      void'(expected_blocks.pop_front());
    end
    if (error_count == 0)
      $display("tb_feistel_arx_cbc_cipher_unit: done, clean");
    else
      $display("tb_feistel_arx_cbc_cipher_unit: done, errors");
    $finish;
  end

endmodule

FILE: feistel_arx_cbc_cipher_unit.f
rtl/fac_pkg.sv
rtl/fac_in_if.sv
rtl/fac_out_if.sv
rtl/fac_key_store.sv
rtl/fac_round_unit.sv
rtl/feistel_arx_cbc_cipher_unit.sv
tb/tb_feistel_arx_cbc_cipher_unit.sv
